/* sv/thsc_pkg.sv */
// Shared types, constants and helper functions for the temperature/humidity
// compensation pipeline. No dependencies; imported by every other file.
`default_nettype none

package thsc_pkg;

    localparam int STAGES = 11;
    localparam int TEMP_STAGES = 3;
    localparam int HUM_STAGES = STAGES - TEMP_STAGES;

    localparam int TEMP_RAW_W = 20;
    localparam int HUM_RAW_W = 16;
    localparam int TEMP_OUT_W = 32;
    localparam int HUM_OUT_W = 17;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 56;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [31:0] HUM_ZERO_POINT = 32'd76800;
    localparam logic [31:0] HUM_CLAMP_MAX = 32'd419430400;
    localparam logic [31:0] HUM_ROUND_A = 32'd16384;
    localparam logic [31:0] HUM_OFFSET_E = 32'd2097152;
    localparam logic [31:0] HUM_ROUND_F = 32'd8192;
    localparam logic [31:0] HUM_OFFSET_C = 32'd32768;
    localparam logic [31:0] TEMP_ROUND = 32'd128;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEMP_TRIM_1 = 3'd0,
        CFG_TEMP_TRIM_2 = 3'd1,
        CFG_TEMP_TRIM_3 = 3'd2,
        CFG_HUM_TRIM_BYTES = 3'd3,
        CFG_HUM_TRIM_2 = 3'd4,
        CFG_HUM_TRIM_4 = 3'd5,
        CFG_HUM_TRIM_5 = 3'd6,
        CFG_HUM_TRIM_6 = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [15:0] temp_trim_1;
        logic [15:0] temp_trim_2;
        logic [15:0] temp_trim_3;
        logic [15:0] hum_trim_bytes;
        logic [15:0] hum_trim_2;
        logic [15:0] hum_trim_4;
        logic [15:0] hum_trim_5;
        logic [7:0]  hum_trim_6;
    } cfg_t;

    // per-stage load enables from the pipeline control
    typedef struct packed {
        logic [STAGES-1:0] en;
    } pipe_ctl_t;

    function automatic logic [31:0] asr32(input logic [31:0] x, input logic [4:0] n);
        logic signed [31:0] xs;
        begin
            xs = $signed(x);
            return 32'(xs >>> n);
        end
    endfunction

    // wrapping 32-bit multiply, low word only
    function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] p;
        begin
            p = a * b;
            return p;
        end
    endfunction

    function automatic logic [31:0] sext16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] sext8(input logic [7:0] v);
        return {{24{v[7]}}, v};
    endfunction

endpackage

`default_nettype wire

/* sv/thsc_cfg_regs.sv */
// Calibration register file written through the plain write port.
// Depends on thsc_pkg.
`default_nettype none

module thsc_cfg_regs
    import thsc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_TEMP_TRIM_1:    cfg_next.temp_trim_1 = cfg_wdata;
                CFG_TEMP_TRIM_2:    cfg_next.temp_trim_2 = cfg_wdata;
                CFG_TEMP_TRIM_3:    cfg_next.temp_trim_3 = cfg_wdata;
                CFG_HUM_TRIM_BYTES: cfg_next.hum_trim_bytes = cfg_wdata;
                CFG_HUM_TRIM_2:     cfg_next.hum_trim_2 = cfg_wdata;
                CFG_HUM_TRIM_4:     cfg_next.hum_trim_4 = cfg_wdata;
                CFG_HUM_TRIM_5:     cfg_next.hum_trim_5 = cfg_wdata;
                CFG_HUM_TRIM_6:     cfg_next.hum_trim_6 = cfg_wdata[7:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* sv/thsc_pipe_ctrl.sv */
// Valid bits and per-stage load enables for the compensation pipeline.
// Depends on thsc_pkg.
`default_nettype none

module thsc_pipe_ctrl
    import thsc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  wire logic m_tready,
    output pipe_ctl_t ctl
);

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES-1:0] en;

    // a stage loads when it is empty or its contents move on; bubbles collapse
    always_comb
    begin
        en[STAGES-1] = !valid_reg[STAGES-1] || m_tready;
        for (int k = STAGES - 2; k >= 0; k--)
            en[k] = !valid_reg[k] || en[k+1];
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (en[0])
            valid_next[0] = s_tvalid;
        for (int k = 1; k < STAGES; k++)
        begin
            if (en[k])
                valid_next[k] = valid_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign s_tready = en[0];
    assign m_tvalid = valid_reg[STAGES-1];
    assign ctl.en = en;

endmodule

`default_nettype wire

/* sv/thsc_temp_path.sv */
// Temperature stages: linear and square trim terms, fine temperature.
// Depends on thsc_pkg; enables come from thsc_pipe_ctrl.
`default_nettype none

module thsc_temp_path
    import thsc_pkg::*;
(
    input  wire logic                  clk,
    input  wire cfg_t                  cfg,
    input  wire logic [TEMP_STAGES-1:0] en,
    input  wire logic [TEMP_RAW_W-1:0] temp_raw,
    input  wire logic [HUM_RAW_W-1:0]  hum_raw,
    output logic [31:0]                fine,
    output logic [31:0]                fine_ofs,
    output logic [HUM_RAW_W-1:0]       hum_raw_out
);

    logic [31:0] lin_prod_reg;
    logic [31:0] sq_reg;
    logic [31:0] v1_reg;
    logic [31:0] sq_prod_reg;
    logic [31:0] fine_reg;
    logic [31:0] fine_ofs_reg;
    logic [HUM_RAW_W-1:0] hum1_reg;
    logic [HUM_RAW_W-1:0] hum2_reg;
    logic [HUM_RAW_W-1:0] hum3_reg;

    logic [31:0] lin_arg;
    logic [31:0] diff;
    logic [31:0] fine_next;

    always_comb
    begin
        lin_arg = 32'(temp_raw >> 3) - {15'd0, cfg.temp_trim_1, 1'b0};
        diff = 32'(temp_raw >> 4) - {16'd0, cfg.temp_trim_1};
        fine_next = v1_reg + asr32(sq_prod_reg, 5'd14);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            lin_prod_reg <= mul32(lin_arg, sext16(cfg.temp_trim_2));
            sq_reg <= mul32(diff, diff);
            hum1_reg <= hum_raw;
        end
        if (en[1])
        begin
            v1_reg <= asr32(lin_prod_reg, 5'd11);
            sq_prod_reg <= mul32(asr32(sq_reg, 5'd12), sext16(cfg.temp_trim_3));
            hum2_reg <= hum1_reg;
        end
        if (en[2])
        begin
            fine_reg <= fine_next;
            fine_ofs_reg <= fine_next - HUM_ZERO_POINT;
            hum3_reg <= hum2_reg;
        end
    end

    assign fine = fine_reg;
    assign fine_ofs = fine_ofs_reg;
    assign hum_raw_out = hum3_reg;

endmodule

`default_nettype wire

/* sv/thsc_hum_path.sv */
// Humidity stages plus final temperature scaling, at most one multiply in
// series per stage, ending in the clamp and the output register. Depends on thsc_pkg.
`default_nettype none

module thsc_hum_path
    import thsc_pkg::*;
(
    input  wire logic                  clk,
    input  wire cfg_t                  cfg,
    input  wire logic [HUM_STAGES-1:0] en,
    input  wire logic [31:0]           fine,
    input  wire logic [31:0]           fine_ofs,
    input  wire logic [HUM_RAW_W-1:0]  hum_raw,
    output logic [TEMP_OUT_W-1:0]      temp_centi_deg,
    output logic [HUM_OUT_W-1:0]       humidity_q10
);

    logic [31:0] temp_reg [HUM_STAGES];
    logic [HUM_RAW_W-1:0] hraw_reg;
    logic [31:0] m5_reg;
    logic [31:0] m6_reg;
    logic [31:0] m3_reg;
    logic [31:0] a_reg [5:7];
    logic [31:0] b_reg;
    logic [31:0] c_reg;
    logic [31:0] bc_reg;
    logic [31:0] ef_reg;
    logic [31:0] af_reg [8:10];
    logic [31:0] ss_reg;
    logic [31:0] sq_h1_reg;
    logic [HUM_OUT_W-1:0] hum_reg;

    logic [31:0] temp_next;
    logic [31:0] a_next;
    logic [31:0] e_val;
    logic [31:0] f_val;
    logic [31:0] s_val;
    logic [31:0] h_val;
    logic [HUM_OUT_W-1:0] hum_next;

    always_comb
    begin
        temp_next = asr32({fine[29:0], 2'b00} + fine + TEMP_ROUND, 5'd8);
        a_next = asr32({2'b00, hraw_reg, 14'd0} - {cfg.hum_trim_4[11:0], 20'd0}
                       - m5_reg + HUM_ROUND_A, 5'd15);
        e_val = asr32(bc_reg, 5'd10) + HUM_OFFSET_E;
        f_val = asr32(ef_reg + HUM_ROUND_F, 5'd14);
        s_val = asr32(af_reg[8], 5'd15);
        h_val = af_reg[10] - asr32(sq_h1_reg, 5'd4);
        // negative goes to zero, above full scale to 100 percent
        if (h_val[31])
            hum_next = '0;
        else if (h_val > HUM_CLAMP_MAX)
            hum_next = HUM_CLAMP_MAX[28:12];
        else
            hum_next = h_val[28:12];
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            temp_reg[0] <= temp_next;
            hraw_reg <= hum_raw;
            m5_reg <= mul32(sext16(cfg.hum_trim_5), fine_ofs);
            m6_reg <= mul32(fine_ofs, sext8(cfg.hum_trim_6));
            m3_reg <= mul32(fine_ofs, {24'd0, cfg.hum_trim_bytes[15:8]});
        end
        for (int k = 1; k < HUM_STAGES; k++)
        begin
            if (en[k])
                temp_reg[k] <= temp_reg[k-1];
        end
        if (en[1])
        begin
            a_reg[5] <= a_next;
            b_reg <= asr32(m6_reg, 5'd10);
            c_reg <= asr32(m3_reg, 5'd11) + HUM_OFFSET_C;
        end
        if (en[2])
        begin
            a_reg[6] <= a_reg[5];
            bc_reg <= mul32(b_reg, c_reg);
        end
        if (en[3])
        begin
            a_reg[7] <= a_reg[6];
            ef_reg <= mul32(e_val, sext16(cfg.hum_trim_2));
        end
        if (en[4])
            af_reg[8] <= mul32(a_reg[7], f_val);
        if (en[5])
        begin
            af_reg[9] <= af_reg[8];
            ss_reg <= mul32(s_val, s_val);
        end
        if (en[6])
        begin
            af_reg[10] <= af_reg[9];
            sq_h1_reg <= mul32(asr32(ss_reg, 5'd7), {24'd0, cfg.hum_trim_bytes[7:0]});
        end
        if (en[7])
            hum_reg <= hum_next;
    end

    assign temp_centi_deg = temp_reg[HUM_STAGES-1];
    assign humidity_q10 = hum_reg;

endmodule

`default_nettype wire

/* sv/temp_humidity_sensor_compensation_top.sv */
// Temperature and humidity compensation with 32-bit integer trim formulas,
// fully pipelined. Takes one raw reading pair per clock and returns one result per
// clock once filled, while the output is not held off by back pressure. There are
// three stages for the temperature terms and the fine temperature and eight for the
// humidity chain and the final clamp, with at most one 32-bit multiply in series in
// any stage. Back pressure on the output stalls only the stages that are full, so
// empty slots are squeezed out. Calibration writes are registered and should only be
// made while no request is in flight. Depends on thsc_pkg and the thsc_* modules.
`default_nettype none

module temp_humidity_sensor_compensation_top
    import thsc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_DATA_W-1:0]   s_tdata,   // temp_raw[19:0], hum_raw[35:20], zero pad
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_DATA_W-1:0]        m_tdata,   // temp_centi_deg[31:0], humidity_q10[48:32], zero pad
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t cfg;
    pipe_ctl_t ctl;
    logic [31:0] fine;
    logic [31:0] fine_ofs;
    logic [HUM_RAW_W-1:0] hum_raw_d;
    logic [TEMP_OUT_W-1:0] temp_centi_deg;
    logic [HUM_OUT_W-1:0] humidity_q10;

    thsc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    thsc_pipe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .ctl      (ctl)
    );

    thsc_temp_path u_temp (
        .clk         (clk),
        .cfg         (cfg),
        .en          (ctl.en[TEMP_STAGES-1:0]),
        .temp_raw    (s_tdata[TEMP_RAW_W-1:0]),
        .hum_raw     (s_tdata[TEMP_RAW_W+HUM_RAW_W-1:TEMP_RAW_W]),
        .fine        (fine),
        .fine_ofs    (fine_ofs),
        .hum_raw_out (hum_raw_d)
    );

    thsc_hum_path u_hum (
        .clk            (clk),
        .cfg            (cfg),
        .en             (ctl.en[STAGES-1:TEMP_STAGES]),
        .fine           (fine),
        .fine_ofs       (fine_ofs),
        .hum_raw        (hum_raw_d),
        .temp_centi_deg (temp_centi_deg),
        .humidity_q10   (humidity_q10)
    );

    assign m_tdata = {{(M_DATA_W - TEMP_OUT_W - HUM_OUT_W){1'b0}}, humidity_q10, temp_centi_deg};

endmodule

`default_nettype wire

/* bench/tb_temp_humidity_sensor_compensation_top.sv */
// Self-checking bench for temp_humidity_sensor_compensation_top: drives raw reading pairs
// over the input stream, predicts each compensated result and checks the output stream.
// Depends on thsc_pkg for the register index enum, the widths and the temperature and humidity constants.

module tb_temp_humidity_sensor_compensation_top;
    import thsc_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_CYCLES = 24;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_REQUESTS = 75;

    typedef struct packed {
        logic [31:0] temp;
        logic [16:0] hum;
    } reading_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;   // temp_raw[19:0], hum_raw[35:20], zero pad
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;   // temp_centi_deg[31:0], humidity_q10[48:32], zero pad
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    // bench copy of the calibration registers
    logic [15:0] trim_word [8];

    reading_t pending_readings [$];
    reading_t want;

    int  errors;
    int  results_checked;
    int  requests_sent;
    int  settings_used;
    int  cycle_count;
    int  ready_hold;
    bit  idle_on;

    temp_humidity_sensor_compensation_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic logic [31:0] shift_right_signed(input logic [31:0] v, input int unsigned n);
        return $unsigned($signed(v) >>> n);
    endfunction

    // Integer trim formulas; every step wraps at 32 bits.
    function automatic reading_t compensate(input logic [19:0] t_raw, input logic [15:0] h_raw);
        logic [31:0] tr, hr, t1, t2, t3, h1, h2, h3, h4, h5, h6;
        logic [31:0] v1, v2, d, fine, x, a, b, c, e, f, p, s;
        reading_t r;
        tr = {12'b0, t_raw};
        hr = {16'b0, h_raw};
        t1 = {16'b0, trim_word[CFG_TEMP_TRIM_1]};
        t2 = 32'($signed(trim_word[CFG_TEMP_TRIM_2]));
        t3 = 32'($signed(trim_word[CFG_TEMP_TRIM_3]));
        h1 = {24'b0, trim_word[CFG_HUM_TRIM_BYTES][7:0]};
        h3 = {24'b0, trim_word[CFG_HUM_TRIM_BYTES][15:8]};
        h2 = 32'($signed(trim_word[CFG_HUM_TRIM_2]));
        h4 = 32'($signed(trim_word[CFG_HUM_TRIM_4]));
        h5 = 32'($signed(trim_word[CFG_HUM_TRIM_5]));
        h6 = 32'($signed(trim_word[CFG_HUM_TRIM_6][7:0]));

        v1 = shift_right_signed(((tr >> 3) - (t1 << 1)) * t2, 11);
        d = (tr >> 4) - t1;
        v2 = shift_right_signed(shift_right_signed(d * d, 12) * t3, 14);
        fine = v1 + v2;
        r.temp = shift_right_signed(fine * 32'd5 + TEMP_ROUND, 8);

        x = fine - HUM_ZERO_POINT;
        a = shift_right_signed((hr << 14) - (h4 << 20) - h5 * x + HUM_ROUND_A, 15);
        b = shift_right_signed(x * h6, 10);
        c = shift_right_signed(x * h3, 11) + HUM_OFFSET_C;
        e = shift_right_signed(b * c, 10) + HUM_OFFSET_E;
        f = shift_right_signed(e * h2 + HUM_ROUND_F, 14);
        p = a * f;
        s = shift_right_signed(p, 15);
        p = p - shift_right_signed(shift_right_signed(s * s, 7) * h1, 4);
        if (p[31])
            p = 32'd0;
        else if (p > HUM_CLAMP_MAX)
            p = HUM_CLAMP_MAX;
        r.hum = p[28:12];
        return r;
    endfunction

    // input side: predict on every accepted request
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            pending_readings.push_back(compensate(s_tdata[19:0], s_tdata[35:20]));
    end

    // output side: compare with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_readings.size() == 0)
            begin
                $error("result with no request pending: m_tdata %0h", m_tdata);
                errors++;
            end
            else
            begin
                want = pending_readings.pop_front();
                results_checked++;
                if (m_tdata[31:0] !== want.temp)
                begin
                    $error("temp_centi_deg: expected %0d, got %0d",
                           $signed(want.temp), $signed(m_tdata[31:0]));
                    errors++;
                end
                if (m_tdata[48:32] !== want.hum)
                begin
                    $error("humidity_q10: expected %0d, got %0d", want.hum, m_tdata[48:32]);
                    errors++;
                end
                if (m_tdata[M_DATA_W-1:49] !== '0)
                begin
                    $error("m_tdata pad: expected 0, got %0h", m_tdata[M_DATA_W-1:49]);
                    errors++;
                end
            end
        end
    end

    // receiver back pressure
    initial
    begin
        m_tready = 1'b0;
        ready_hold = 0;
        forever
        begin
            @(negedge clk);
            if (ready_hold > 0)
                ready_hold--;
            else if (!idle_on)
                m_tready = 1'b1;
            else if ($urandom_range(0, 9) < 7)
            begin
                m_tready = 1'b1;
                ready_hold = $urandom_range(0, 7);
            end
            else
            begin
                m_tready = 1'b0;
                ready_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(0, 2);
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $error("timeout with %0d results still pending", pending_readings.size());
        $display("status: fail");
        $finish;
    end

    // All tasks start and end right after a falling edge.
    task automatic write_reg(input cfg_idx_t idx, input logic [15:0] value);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        trim_word[idx] = value;
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic write_trims(input logic [15:0] t1, input logic [15:0] t2,
                               input logic [15:0] t3, input logic [15:0] hb,
                               input logic [15:0] h2, input logic [15:0] h4,
                               input logic [15:0] h5, input logic [15:0] h6);
        write_reg(CFG_TEMP_TRIM_1, t1);
        write_reg(CFG_TEMP_TRIM_2, t2);
        write_reg(CFG_TEMP_TRIM_3, t3);
        write_reg(CFG_HUM_TRIM_BYTES, hb);
        write_reg(CFG_HUM_TRIM_2, h2);
        write_reg(CFG_HUM_TRIM_4, h4);
        write_reg(CFG_HUM_TRIM_5, h5);
        write_reg(CFG_HUM_TRIM_6, h6);
        settings_used++;
    endtask

    task automatic send_reading(input logic [19:0] t_raw, input logic [15:0] h_raw);
        int gap;
        gap = 0;
        if (idle_on)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: gap = 0;
                6, 7, 8:          gap = $urandom_range(1, 3);
                default:          gap = $urandom_range(15, 50);
            endcase
        end
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata = {4'b0, h_raw, t_raw};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        requests_sent++;
        @(negedge clk);
    endtask

    // wait until every request has come back so the trims can change
    task automatic drain;
        s_tvalid = 1'b0;
        while (pending_readings.size() != 0)
            @(negedge clk);
    endtask

    task automatic send_corners;
        send_reading(20'h00000, 16'h0000);
        send_reading(20'hFFFFF, 16'hFFFF);
        send_reading(20'h00000, 16'hFFFF);
        send_reading(20'hFFFFF, 16'h0000);
    endtask

    task automatic test_reset_trims;
        idle_on = 1'b1;
        send_corners();
        drain();
    endtask

    task automatic test_nominal_trims;
        idle_on = 1'b1;
        write_trims(16'd27504, 16'd26435, -16'sd1000, {8'd0, 8'd75},
                    16'd362, 16'd313, 16'd50, 16'd30);
        send_reading(20'd519888, 16'd30000);
        send_reading(20'd480000, 16'd22000);
        send_reading(20'd560000, 16'hFFFF);   // saturates at full scale
        send_reading(20'd519888, 16'h0000);   // clamps to zero
        send_reading(20'h00000, 16'd30000);
        send_reading(20'hFFFFF, 16'd30000);
        drain();
    endtask

    task automatic test_extreme_trims;
        idle_on = 1'b1;
        write_trims(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                    16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h00FF);
        send_corners();
        drain();
        write_trims(16'hFFFF, 16'h7FFF, 16'h7FFF, 16'hFFFF,
                    16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFF7F);
        send_corners();
        drain();
        write_trims(16'h0000, 16'h8000, 16'h8000, 16'h0000,
                    16'h8000, 16'h8000, 16'h8000, 16'h0080);
        send_corners();
        drain();
    endtask

    task automatic test_random_phases;
        int kind;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            kind = phase % 3;
            idle_on = (kind != 0);
            if (kind == 2)
                write_trims(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                            16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                            16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                            16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
            else
                write_trims(16'($urandom_range(27000, 29000)),
                            16'($urandom_range(26000, 27000)),
                            16'($urandom_range(0, 500) - 1000),
                            16'($urandom_range(0, 65535)),
                            16'($urandom_range(300, 420)), 16'($urandom_range(250, 400)),
                            16'($urandom_range(0, 100)), 16'($urandom_range(0, 60)));
            for (int n = 0; n < PHASE_REQUESTS; n++)
            begin
                if ($urandom_range(0, 3) != 0)
                    send_reading(20'($urandom_range(400000, 620000)),
                                 16'($urandom_range(15000, 45000)));
                else
                    send_reading(20'($urandom()), 16'($urandom()));
            end
            drain();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        idle_on = 1'b0;
        errors = 0;
        results_checked = 0;
        requests_sent = 0;
        settings_used = 0;
        for (int i = 0; i < 8; i++)
            trim_word[i] = 16'h0000;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_trims();
        test_nominal_trims();
        test_extreme_trims();
        test_random_phases();

        idle_on = 1'b0;
        drain();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (pending_readings.size() != 0)
        begin
            $error("%0d results never arrived", pending_readings.size());
            errors++;
        end

        $display("Checked %0d results from %0d requests over %0d trim settings,",
                 results_checked, requests_sent, settings_used + 1);
        $display("with reset, nominal, extreme and random trims and stalls on both sides.");
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
